### hw/rtl/vt4_pkg.sv
`timescale 1ns / 1ps
// Package for the 4x4 vertex transform: item kinds, fixed-point widths and
// the stage record handed along the cell chain. No dependencies.
package vt4_pkg;

  // Field widths and fixed-point constants.
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_W   = 16;
  localparam int NUM_ROWS = 4;
  localparam int IDX_W    = 2;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(65536);

  // Item kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_VECTOR = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // One item as it moves down the chain.
  typedef struct packed {
    logic                              valid;
    logic [1:0]                        kind;
    logic [IDX_W-1:0]                  row;
    logic [IDX_W-1:0]                  col;
    logic [DATA_W-1:0]                 value;
    logic [NUM_ROWS-1:0][DATA_W-1:0]   vec;
  } stage_t;

  // One finished result.
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
    logic              clipped;
  } result_t;

endpackage

### hw/rtl/vt4_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the vertex transform input and output.
// Standalone; no package needed.
interface vt4_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         elem_row;
  logic [1:0]         elem_col;
  logic signed [31:0] elem_value;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;

  modport source (output valid, kind, elem_row, elem_col, elem_value,
                  in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, kind, elem_row, elem_col, elem_value,
                in_x, in_y, in_z, in_w, output ready);
endinterface

interface vt4_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               clipped;

  modport source (output valid, out_x, out_y, out_z, out_w, clipped,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, clipped,
                output ready);
endinterface

### hw/rtl/vt4_cell.sv
`timescale 1ns / 1ps
// One column cell of the transform chain: holds one matrix column, multiplies
// it by its vector component and folds the previous cell's products in.
// Depends on vt4_pkg.
module vt4_cell #(
  parameter int COL = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  vt4_pkg::stage_t stage_in,
  input  vt4_pkg::acc_t   acc_in   [vt4_pkg::NUM_ROWS],
  input  vt4_pkg::prod_t  prod_in  [vt4_pkg::NUM_ROWS],
  output vt4_pkg::stage_t stage_out,
  output vt4_pkg::acc_t   acc_out  [vt4_pkg::NUM_ROWS],
  output vt4_pkg::prod_t  prod_out [vt4_pkg::NUM_ROWS]
);
  import vt4_pkg::*;

  logic signed [DATA_W-1:0] column [NUM_ROWS];
  logic signed [DATA_W-1:0] comp;
  prod_t                    prod_next [NUM_ROWS];
  logic                     load_here;

  // The vector component this cell owns, and whether a load targets it.
  assign comp      = $signed(stage_in.vec[COL]);
  assign load_here = stage_in.valid && (stage_in.kind == KIND_LOAD) &&
                     (stage_in.col == IDX_W'(COL));

  // Row products of this column.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prod_next[r] = column[r] * comp;
    end
  end

  // Column storage, reset to this column of the identity. A load is applied
  // as the load item passes, so it stays ordered with transform items.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        column[r] <= (r == COL) ? Q_ONE : '0;
      end
    end else if (en && load_here) begin
      column[stage_in.row] <= $signed(stage_in.value);
    end
  end

  // Stage record handed to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out <= stage_in;
    end
  end

  // Products and running sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        prod_out[r] <= prod_next[r];
        acc_out[r]  <= acc_in[r] + ACC_W'(prod_in[r]);
      end
    end
  end

endmodule

### hw/rtl/vt4_sat.sv
`timescale 1ns / 1ps
// Tail of the chain: adds the last column's products, then shifts, saturates
// and holds the result in the output register. Depends on vt4_pkg.
module vt4_sat (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  vt4_pkg::stage_t  stage_in,
  input  vt4_pkg::acc_t    acc_in  [vt4_pkg::NUM_ROWS],
  input  vt4_pkg::prod_t   prod_in [vt4_pkg::NUM_ROWS],
  output logic             res_valid,
  output vt4_pkg::result_t res
);
  import vt4_pkg::*;

  localparam acc_t SAT_MAX = ACC_W'(64'sd2147483647);
  localparam acc_t SAT_MIN = -ACC_W'(64'sd2147483648);

  logic                     sum_valid;
  logic                     sum_point;
  acc_t                     sum [NUM_ROWS];
  acc_t                     shifted [NUM_ROWS];
  logic [NUM_ROWS-1:0]      clip;
  logic [NUM_ROWS-1:0][DATA_W-1:0] val;
  logic                     xform;

  assign xform = stage_in.valid &&
                 ((stage_in.kind == KIND_POINT) || (stage_in.kind == KIND_VECTOR));

  // Final sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= xform;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_point <= (stage_in.kind == KIND_POINT);
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum[r] <= acc_in[r] + ACC_W'(prod_in[r]);
      end
    end
  end

  // Floor shift and saturation to 32 bits; row three is dropped for points.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      shifted[r] = sum[r] >>> FRAC_W;
      clip[r]    = (shifted[r] > SAT_MAX) || (shifted[r] < SAT_MIN);
      if (shifted[r] > SAT_MAX) begin
        val[r] = SAT_MAX[DATA_W-1:0];
      end else if (shifted[r] < SAT_MIN) begin
        val[r] = SAT_MIN[DATA_W-1:0];
      end else begin
        val[r] = shifted[r][DATA_W-1:0];
      end
    end
    if (sum_point) begin
      clip[NUM_ROWS-1] = 1'b0;
      val[NUM_ROWS-1]  = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.x       <= val[0];
      res.y       <= val[1];
      res.z       <= val[2];
      res.w       <= val[3];
      res.clipped <= |clip;
    end
  end

endmodule

### hw/rtl/vertex_transform_4x4_top.sv
`timescale 1ns / 1ps
// 4x4 matrix-vector multiply on signed Q16.16 data, matrix reset to identity.
// Every item is a single transfer and the block takes one item per clock
// unless a held result stalls the chain. A point or vector item passes six
// register stages: four column cells (each with four 32x32 multipliers), a
// final sum stage and the output register. The first cell loads at the accepting edge.
// The whole chain advances whenever the output register is empty or being
// drained, so input ready drops only while a result is held.
// A load item travels down the chain and updates its column as it passes,
// so it affects exactly the items accepted after it. Depends on vt4_pkg,
// vt4_if, vt4_cell and vt4_sat.
module vertex_transform_4x4_top (
  input logic       clk,
  input logic       rst,
  vt4_in_if.sink    vin,
  vt4_out_if.source vout
);
  import vt4_pkg::*;

  localparam int NUM_CELLS = NUM_ROWS;

  logic    en;
  stage_t  stage [NUM_CELLS+1];
  acc_t    acc   [NUM_CELLS+1][NUM_ROWS];
  prod_t   prod  [NUM_CELLS+1][NUM_ROWS];
  logic    res_valid;
  result_t res;

  // Chain advances unless a held result is stalled.
  assign en        = !res_valid || vout.ready;
  assign vin.ready = en;

  // Entry record; point items get w of 1.0, unused kinds are dropped.
  always_comb begin
    stage[0].valid  = vin.valid && (vin.kind != KIND_NONE);
    stage[0].kind   = vin.kind;
    stage[0].row    = vin.elem_row;
    stage[0].col    = vin.elem_col;
    stage[0].value  = vin.elem_value;
    stage[0].vec[0] = vin.in_x;
    stage[0].vec[1] = vin.in_y;
    stage[0].vec[2] = vin.in_z;
    stage[0].vec[3] = (vin.kind == KIND_POINT) ? Q_ONE : vin.in_w;
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc[0][r]  = '0;
      prod[0][r] = '0;
    end
  end

  // Column cells.
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    vt4_cell #(.COL(c)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage_in  (stage[c]),
      .acc_in    (acc[c]),
      .prod_in   (prod[c]),
      .stage_out (stage[c+1]),
      .acc_out   (acc[c+1]),
      .prod_out  (prod[c+1])
    );
  end

  vt4_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .stage_in  (stage[NUM_CELLS]),
    .acc_in    (acc[NUM_CELLS]),
    .prod_in   (prod[NUM_CELLS]),
    .res_valid (res_valid),
    .res       (res)
  );

  assign vout.valid   = res_valid;
  assign vout.out_x   = res.x;
  assign vout.out_y   = res.y;
  assign vout.out_z   = res.z;
  assign vout.out_w   = res.w;
  assign vout.clipped = res.clipped;

`ifndef SYNTH
  // A clipped result has at least one component at a saturation limit.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    vout.valid && vout.clipped |->
      (vout.out_x == 32'sh7fffffff) || (vout.out_x == 32'sh80000000) ||
      (vout.out_y == 32'sh7fffffff) || (vout.out_y == 32'sh80000000) ||
      (vout.out_z == 32'sh7fffffff) || (vout.out_z == 32'sh80000000) ||
      (vout.out_w == 32'sh7fffffff) || (vout.out_w == 32'sh80000000))
    else $error("clipped set without a saturated component");

  // No result can be pending right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !vout.valid)
    else $error("result valid right after reset");

  // Taking a result always frees the chain for a new item.
  a_drain_frees_input: assert property (@(posedge clk) disable iff (rst)
    vout.valid && vout.ready |-> vin.ready)
    else $error("input stalled while the result is taken");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for vertex_transform_4x4_top: drives load, point and vector items,
// predicts each Q16.16 result from its own matrix copy, and checks every output.
// Depends on vt4_pkg, vt4_if and the vertex_transform_4x4_top RTL.
module tb;
  import vt4_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 480;

  // One input item as it sits in the stimulus queue.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } vt_item_t;

  logic clk = 1'b0;
  logic rst;

  vt4_in_if  vin ();
  vt4_out_if vout ();

  vertex_transform_4x4_top DUT (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin),
    .vout (vout)
  );

  always #2 clk = ~clk;

  wire in_fire  = vin.valid && vin.ready;
  wire out_fire = vout.valid && vout.ready;

  vt_item_t           vertex_q [$];
  result_t            result_q [$];
  logic signed [31:0] matrix_q [16];

  int err_cnt;
  int load_cnt;
  int point_cnt;
  int vector_cnt;
  int ignored_cnt;
  int clipped_cnt;
  int result_cnt;
  int in_stall_cnt;
  logic hold_off;

  // Exact row dot product, floored by 16 bits and saturated; bit 32 flags saturation.
  function automatic logic [32:0] row_q16(input int r, input logic [3:0][31:0] v);
    logic signed [67:0] acc;
    logic signed [63:0] prod;
    logic signed [67:0] sum_q16;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      prod = $signed(matrix_q[r*4+c]) * $signed(v[c]);
      acc = acc + prod;
    end
    sum_q16 = acc >>> 16;
    if (sum_q16 > 68'sh0_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (sum_q16 < -68'sh0_8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, sum_q16[31:0]};
  endfunction

  // Apply one accepted item to the matrix copy and queue the result it yields.
  task automatic transform_item(input vt_item_t it);
    logic [3:0][31:0] v;
    logic [32:0] r0, r1, r2, r3;
    result_t res;
    unique case (it.kind)
      KIND_LOAD: begin
        matrix_q[{it.row, it.col}] = it.value;
        load_cnt++;
      end
      KIND_POINT, KIND_VECTOR: begin
        v = {(it.kind == KIND_POINT) ? Q_ONE : it.w, it.z, it.y, it.x};
        r0 = row_q16(0, v);
        r1 = row_q16(1, v);
        r2 = row_q16(2, v);
        r3 = (it.kind == KIND_VECTOR) ? row_q16(3, v) : 33'd0;
        res.x = r0[31:0];
        res.y = r1[31:0];
        res.z = r2[31:0];
        res.w = r3[31:0];
        res.clipped = r0[32] | r1[32] | r2[32] | r3[32];
        result_q.push_back(res);
        if (it.kind == KIND_POINT) point_cnt++;
        else vector_cnt++;
      end
      default: ignored_cnt++;
    endcase
  endtask

  // Idle cycles before the next item; now and then a run of items with no idling.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(20, 60);
    return $urandom_range(0, 9);
  endfunction

  // Q16.16 value: mostly moderate, some full range, some corner values.
  function automatic logic [31:0] pick_q16(input int mod_bits, input int full_pct);
    int sel;
    logic signed [31:0] r;
    sel = $urandom_range(0, 99);
    r = $urandom;
    if (sel < 15) begin
      unique case ($urandom_range(0, 6))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0;
        3: return Q_ONE;
        4: return -Q_ONE;
        5: return 32'h1;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (sel < 15 + full_pct) return $urandom;
    return r >>> (32 - mod_bits);
  endfunction

  function automatic vt_item_t make_item(input logic [1:0] kind, input int row,
                                         input int col, input logic [31:0] value,
                                         input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input logic [31:0] w);
    vt_item_t it;
    it.kind = kind;
    it.row = 2'(row);
    it.col = 2'(col);
    it.value = value;
    it.x = x;
    it.y = y;
    it.z = z;
    it.w = w;
    return it;
  endfunction

  function automatic vt_item_t random_item(input logic [1:0] kind);
    vt_item_t it;
    it.kind = kind;
    it.row = 2'($urandom_range(0, 3));
    it.col = 2'($urandom_range(0, 3));
    it.value = pick_q16(19, 15);
    it.x = pick_q16(27, 25);
    it.y = pick_q16(27, 25);
    it.z = pick_q16(27, 25);
    it.w = pick_q16(27, 25);
    return it;
  endfunction

  // Driver: presents queued items, predicting each one at its transfer.
  vt_item_t cur_item;
  int send_wait;
  int send_burst;
  always @(posedge clk) begin
    if (rst) begin
      vin.valid <= 1'b0;
      send_wait = 0;
      send_burst = 0;
    end else begin
      if (in_fire) transform_item(cur_item);
      if (!vin.valid || in_fire) begin
        if (send_wait != 0) begin
          send_wait--;
          vin.valid <= 1'b0;
        end else if (vertex_q.size() != 0) begin
          cur_item = vertex_q.pop_front();
          vin.kind       <= cur_item.kind;
          vin.elem_row   <= cur_item.row;
          vin.elem_col   <= cur_item.col;
          vin.elem_value <= cur_item.value;
          vin.in_x       <= cur_item.x;
          vin.in_y       <= cur_item.y;
          vin.in_z       <= cur_item.z;
          vin.in_w       <= cur_item.w;
          vin.valid      <= 1'b1;
          send_wait = draw_wait(send_burst);
        end else begin
          vin.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  result_t want;
  int recv_wait;
  int recv_burst;
  always @(posedge clk) begin
    if (rst) begin
      vout.ready <= 1'b0;
      recv_wait = 0;
      recv_burst = 0;
    end else begin
      if (out_fire) begin
        result_cnt++;
        if (vout.clipped === 1'b1) clipped_cnt++;
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("tb: unexpected result x=%h y=%h z=%h w=%h clipped=%b",
                     vout.out_x, vout.out_y, vout.out_z, vout.out_w, vout.clipped);
        end else begin
          want = result_q.pop_front();
          if (vout.out_x !== want.x || vout.out_y !== want.y || vout.out_z !== want.z ||
              vout.out_w !== want.w || vout.clipped !== want.clipped) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("tb: mismatch exp x=%h y=%h z=%h w=%h c=%b got x=%h y=%h z=%h w=%h c=%b",
                       want.x, want.y, want.z, want.w, want.clipped,
                       vout.out_x, vout.out_y, vout.out_z, vout.out_w, vout.clipped);
          end
        end
        recv_wait = draw_wait(recv_burst);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        vout.ready <= 1'b0;
      end else begin
        vout.ready <= !hold_off;
      end
    end
  end

  // One long receiver hold-off partway through, so the chain fills and stalls input.
  int xfer_seen;
  int hold_cnt;
  logic hold_done;
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
      xfer_seen <= 0;
    end else begin
      if (in_fire) xfer_seen <= xfer_seen + 1;
      if (!hold_done && !hold_off && xfer_seen >= 120) begin
        hold_off <= 1'b1;
        hold_cnt <= 0;
      end else if (hold_off) begin
        if (hold_cnt == HOLD_CYCLES - 1) begin
          hold_off <= 1'b0;
          hold_done <= 1'b1;
        end else begin
          hold_cnt <= hold_cnt + 1;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  int idle_cnt;
  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      idle_cnt <= 0;
    end else if (idle_cnt == WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired with %0d results outstanding", result_q.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (!rst && vin.valid && !vin.ready) in_stall_cnt++;
  end

  // Stimulus, reset and end of run.
  int counted;
  int n;
  initial begin
    rst = 1'b1;
    vin.valid = 1'b0;
    vin.kind = KIND_LOAD;
    vin.elem_row = '0;
    vin.elem_col = '0;
    vin.elem_value = '0;
    vin.in_x = '0;
    vin.in_y = '0;
    vin.in_z = '0;
    vin.in_w = '0;
    vout.ready = 1'b0;
    for (int i = 0; i < 16; i++) matrix_q[i] = ((i & 3) == (i >> 2)) ? Q_ONE : 32'sd0;

    // Identity matrix: point ignores its w, vector passes extremes through unchanged.
    vertex_q.push_back(make_item(KIND_POINT, 0, 0, 0, 32'h0001_8000, 32'hFFFD_C000,
                                 32'h0003_0000, 32'h1234_5678));
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'hFFFF_FFFF, 32'h1));
    // Unused kind must not write the element it names.
    vertex_q.push_back(make_item(KIND_NONE, 3, 3, 0, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 0, 0, 0, Q_ONE));
    // Translation column with extremes; the point adds it in and row two saturates.
    vertex_q.push_back(make_item(KIND_LOAD, 0, 3, 32'h000A_0000, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_LOAD, 1, 3, 32'h8000_0000, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_LOAD, 2, 3, 32'h7FFF_FFFF, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_POINT, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 32'h8000_0000));
    // Row three would saturate, but a point leaves it out of the clip flag.
    vertex_q.push_back(make_item(KIND_LOAD, 3, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_POINT, 0, 0, 0, 32'h4000_0000, 0, 0, 32'h7FFF_FFFF));
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 32'h4000_0000, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_LOAD, 3, 1, 32'h8000_0000, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_LOAD, 3, 2, 32'hFFFF_FFFF, 0, 0, 0, 0));
    // Negative and mixed saturation.
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000));
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h1, 32'hFFFF_FFFF));
    vertex_q.push_back(make_item(KIND_LOAD, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 32'h8000_0000, 0, 0, 0));
    // A half times minus one ulp must floor to minus one ulp.
    vertex_q.push_back(make_item(KIND_LOAD, 1, 1, 32'h0000_8000, 0, 0, 0, 0));
    vertex_q.push_back(make_item(KIND_VECTOR, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
    vertex_q.push_back(random_item(KIND_NONE));
    vertex_q.push_back(make_item(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));

    // Random part: element loads, then a run of transforms on that matrix.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < 16; i++) begin
          vertex_q.push_back(random_item(KIND_LOAD));
          vertex_q[$].row = 2'(i >> 2);
          vertex_q[$].col = 2'(i & 3);
        end
        counted += 16;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) vertex_q.push_back(random_item(KIND_LOAD));
        counted += n;
      end
      n = $urandom_range(2, 12);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) vertex_q.push_back(random_item(KIND_NONE));
        vertex_q.push_back(random_item(($urandom_range(0, 1) == 0) ? KIND_POINT : KIND_VECTOR));
      end
      counted += n;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (vertex_q.size() != 0 || vin.valid) @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb: %0d loads, %0d points, %0d vectors, %0d unused-kind items accepted",
             load_cnt, point_cnt, vector_cnt, ignored_cnt);
    $display("tb: %0d results checked, %0d clipped, %0d input stall cycles, %0d errors",
             result_cnt, clipped_cnt, in_stall_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### vertex_transform_4x4_top.f
hw/rtl/vt4_pkg.sv
hw/rtl/vt4_if.sv
hw/rtl/vt4_cell.sv
hw/rtl/vt4_sat.sv
hw/rtl/vertex_transform_4x4_top.sv
dv/tb.sv
